// ===== hdl/elg_pkg.sv =====
// Package for the ElGamal signature verify stream block.
// Holds the stream widths, register indexes, reset values and state types.
// Used by elg_modmul and elgamal_signature_verify_stream.
`default_nettype none

package elg_pkg;

	localparam int MOD_BITS_DEF = 24;
	localparam int EXP_BITS_DEF = 64;

	localparam int HASH_W    = 8;
	localparam int SIG_W     = 64;
	localparam int S_TDATA_W = 136;
	localparam int M_TDATA_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_KEY = 2'd2;

	localparam logic [31:0] RST_MODULUS    = 32'd1000003;
	localparam logic [31:0] RST_GENERATOR  = 32'd2;
	localparam logic [31:0] RST_PUBLIC_KEY = 32'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RED,
		ST_EXP,
		ST_MUL_ACC,
		ST_MUL_SQR,
		ST_COMB,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_Y,
		PH_R,
		PH_G
	} phase_t;

endpackage

`default_nettype wire

// ===== hdl/elg_modmul.sv =====
// Iterative modular multiplier: result = a * b mod modulus, one bit of a per cycle.
// Requires b < modulus; a may be any value. Uses elg_pkg.
`default_nettype none

module elg_modmul #(
	parameter int MOD_BITS = elg_pkg::MOD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MOD_BITS-1:0] a,
	input  logic [MOD_BITS-1:0] b,
	input  logic [MOD_BITS-1:0] modulus,
	output logic                done,
	output logic [MOD_BITS-1:0] result
);
	import elg_pkg::*;

	localparam int CNT_W = $clog2(MOD_BITS + 1);

	logic [MOD_BITS-1:0] a_q;
	logic [MOD_BITS-1:0] b_q;
	logic [MOD_BITS-1:0] p_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [MOD_BITS+1:0] sum;
	logic [MOD_BITS+1:0] p_ext;
	logic [MOD_BITS+1:0] red1;
	logic [MOD_BITS+1:0] red2;

	always_comb begin
		p_ext = {2'b00, p_q};
		sum   = {1'b0, acc_q, 1'b0} + {2'b00, (a_q[MOD_BITS-1] ? b_q : '0)};
		red1  = (sum >= p_ext) ? (sum - p_ext) : sum;
		red2  = (red1 >= p_ext) ? (red1 - p_ext) : red1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MOD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			p_q   <= modulus;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= {a_q[MOD_BITS-2:0], 1'b0};
			acc_q <= red2[MOD_BITS-1:0];
		end
	end

	assign done   = done_q;
	assign result = acc_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("Multiplier started while busy.");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (acc_q < p_q))
		else $error("Partial product left the residue range.");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("Done held for more than one cycle.");

endmodule

`default_nettype wire

// ===== hdl/elgamal_signature_verify_stream.sv =====
// ElGamal signature verification, one hash byte and signature pair per transaction.
// Top level: handshakes, configuration registers and the exponentiation sequencer.
// Depends on elg_pkg and elg_modmul.
//
// Usage: configuration writes (index 0 modulus, 1 generator, 2 public key, any
// other index ignored) are taken on every cycle on the cfg channel, and must only
// be issued while the block is idle. The input stream carries hash byte, r and s
// in s_tdata and the end-of-run mark in s_tlast. Each input transaction gives one
// output transaction with the pair pass flag and the running all-pass flag in
// m_tdata and the end-of-run mark in m_tlast.
// The sequencer takes one item at a time. A pair with r out of range skips the
// multiplies and goes straight to output as a failed pair. Otherwise the modular
// multiplies run on the shared bit-serial multiplier, and an item needs 3 + bits(r) +
// ones(r) + bits(s) + ones(s) + bits(m) + ones(m) multiplies, less one per nonzero
// exponent.
// Reset clears the sequencer, the output valid and sets the running flag; the
// configuration registers return to their defaults. A stalled receiver holds the
// result in the output register; the next item is accepted meanwhile and waits
// at its end until the output register is free.
`default_nettype none

module elgamal_signature_verify_stream #(
	parameter int MOD_BITS = elg_pkg::MOD_BITS_DEF,
	parameter int EXP_BITS = elg_pkg::EXP_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0: hash_byte[7:0], sig_r[71:8], sig_s[135:72].
	input  logic [elg_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Fields from bit 0: pair_ok[0], all_ok[1], zero padding above.
	output logic [elg_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [elg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [MOD_BITS-1:0]            cfg_data
);
	import elg_pkg::*;

	localparam logic [MOD_BITS-1:0] ONE = MOD_BITS'(1);

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	logic [MOD_BITS-1:0] modulus_q;
	logic [MOD_BITS-1:0] generator_q;
	logic [MOD_BITS-1:0] public_key_q;

	logic [HASH_W-1:0]   m_q;
	logic [MOD_BITS-1:0] r_q;
	logic [EXP_BITS-1:0] s_q;
	logic                last_q;
	logic                range_ok_q;

	logic [MOD_BITS-1:0] base_q, base_d;
	logic [MOD_BITS-1:0] acc_q, acc_d;
	logic [MOD_BITS-1:0] t1_q, t1_d;
	logic [MOD_BITS-1:0] lhs_q, lhs_d;
	logic [EXP_BITS-1:0] e_q, e_d;
	logic                pair_ok_q, pair_ok_d;
	logic                running_q;

	logic                m_tvalid_q;
	logic                m_pair_q;
	logic                m_all_q;
	logic                m_last_q;

	logic [HASH_W-1:0]   in_hash;
	logic [SIG_W-1:0]    in_r;
	logic [SIG_W-1:0]    in_s;
	logic                in_range_ok;
	logic                in_accept;
	logic                out_load;

	logic                mm_start;
	logic [MOD_BITS-1:0] mm_a;
	logic [MOD_BITS-1:0] mm_b;
	logic                mm_done;
	logic [MOD_BITS-1:0] mm_result;

	assign in_hash     = s_tdata[HASH_W-1:0];
	assign in_r        = s_tdata[HASH_W +: SIG_W];
	assign in_s        = s_tdata[HASH_W+SIG_W +: SIG_W];
	assign in_range_ok = (in_r != '0) && (in_r < {{(SIG_W-MOD_BITS){1'b0}}, modulus_q});
	assign in_accept   = s_tvalid && s_tready;
	assign cfg_ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q    <= MOD_BITS'(RST_MODULUS);
			generator_q  <= MOD_BITS'(RST_GENERATOR);
			public_key_q <= MOD_BITS'(RST_PUBLIC_KEY);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODULUS:    modulus_q    <= cfg_data;
				CFG_GENERATOR:  generator_q  <= cfg_data;
				CFG_PUBLIC_KEY: public_key_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		base_d    = base_q;
		acc_d     = acc_q;
		t1_d      = t1_q;
		lhs_d     = lhs_q;
		e_d       = e_q;
		pair_ok_d = pair_ok_q;
		mm_start  = 1'b0;
		mm_a      = acc_q;
		mm_b      = base_q;
		out_load  = 1'b0;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!range_ok_q) begin
					pair_ok_d = 1'b0;
					state_d   = ST_OUT;
				end else begin
					phase_d  = PH_Y;
					mm_start = 1'b1;
					mm_a     = public_key_q;
					mm_b     = ONE;
					state_d  = ST_RED;
				end
			end
			ST_RED: begin
				if (mm_done) begin
					base_d  = mm_result;
					acc_d   = ONE;
					e_d     = (phase_q == PH_G) ? EXP_BITS'(m_q) : EXP_BITS'(r_q);
					state_d = ST_EXP;
				end
			end
			ST_EXP: begin
				if (e_q == '0) begin
					unique case (phase_q)
						PH_Y: begin
							t1_d    = acc_q;
							phase_d = PH_R;
							base_d  = r_q;
							acc_d   = ONE;
							e_d     = s_q;
						end
						PH_R: begin
							mm_start = 1'b1;
							mm_a     = t1_q;
							mm_b     = acc_q;
							state_d  = ST_COMB;
						end
						PH_G: begin
							pair_ok_d = (acc_q == lhs_q);
							state_d   = ST_OUT;
						end
						default: state_d = ST_IDLE;
					endcase
				end else if (e_q[0]) begin
					mm_start = 1'b1;
					state_d  = ST_MUL_ACC;
				end else begin
					mm_start = 1'b1;
					mm_a     = base_q;
					state_d  = ST_MUL_SQR;
				end
			end
			ST_MUL_ACC: begin
				if (mm_done) begin
					acc_d = mm_result;
					if (e_q[EXP_BITS-1:1] == '0) begin
						e_d     = '0;
						state_d = ST_EXP;
					end else begin
						mm_start = 1'b1;
						mm_a     = base_q;
						state_d  = ST_MUL_SQR;
					end
				end
			end
			ST_MUL_SQR: begin
				if (mm_done) begin
					base_d  = mm_result;
					e_d     = e_q >> 1;
					state_d = ST_EXP;
				end
			end
			ST_COMB: begin
				if (mm_done) begin
					lhs_d    = mm_result;
					phase_d  = PH_G;
					mm_start = 1'b1;
					mm_a     = generator_q;
					mm_b     = ONE;
					state_d  = ST_RED;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_Y;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		base_q    <= base_d;
		acc_q     <= acc_d;
		t1_q      <= t1_d;
		lhs_q     <= lhs_d;
		e_q       <= e_d;
		pair_ok_q <= pair_ok_d;
		if (in_accept) begin
			m_q        <= in_hash;
			r_q        <= in_r[MOD_BITS-1:0];
			s_q        <= in_s[EXP_BITS-1:0];
			last_q     <= s_tlast;
			range_ok_q <= in_range_ok;
		end
		if (out_load) begin
			m_pair_q <= pair_ok_q;
			m_all_q  <= pair_ok_q & running_q;
			m_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			running_q  <= 1'b1;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
			running_q  <= last_q | (pair_ok_q & running_q);
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, m_all_q, m_pair_q};
	assign m_tlast  = m_last_q;

	elg_modmul #(
		.MOD_BITS(MOD_BITS)
	) u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.a       (mm_a),
		.b       (mm_b),
		.modulus (modulus_q),
		.done    (mm_done),
		.result  (mm_result)
	);

	a_all_implies_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
		else $error("Running pass flag set on a failed pair.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_tready)
		else $error("Input ready while an item is in work.");

	a_run_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_q) |=> running_q)
		else $error("Running flag not restored at the end of a run.");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == ST_RED || state_q == ST_MUL_ACC ||
			state_q == ST_MUL_SQR || state_q == ST_COMB))
		else $error("Multiplier finished with no step waiting for it.");

endmodule

`default_nettype wire
